### rtl/fbsp_pkg.sv
// ----------------------------------------------------------------------------
// Framed byte stream parser package
// Shared widths, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package fbsp_pkg;

  localparam int MaxPayload = 32;
  localparam int ByteW      = 8;
  localparam int LenW       = 7;
  localparam int PlenW      = 6;
  localparam int StatusW    = 2;
  localparam int AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CfgFirstHeader  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondHeader = 2'd1;

  localparam logic [ByteW-1:0] FirstHeaderReset  = 8'd170;
  localparam logic [ByteW-1:0] SecondHeaderReset = 8'd85;

  localparam logic [StatusW-1:0] StGood   = 2'd0;
  localparam logic [StatusW-1:0] StLenErr = 2'd1;
  localparam logic [StatusW-1:0] StSumErr = 2'd2;

  localparam logic [1:0] OutLenErr    = 2'd0;
  localparam logic [1:0] OutSumErr    = 2'd1;
  localparam logic [1:0] OutGoodEmpty = 2'd2;
  localparam logic [1:0] OutPayload   = 2'd3;

  typedef struct packed {
    logic       take_length;
    logic       take_body;
    logic       out_load;
    logic [1:0] out_sel;
    logic       rd_en;
    logic       rd_start;
    logic       rd_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_first;
    logic is_second;
    logic len_bad;
    logic body_end;
    logic sum_ok;
    logic plen_zero;
    logic rd_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/fbsp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                       wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                       rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/fbsp_datapath.sv
// ----------------------------------------------------------------------------
// Parser datapath
// Header registers, frame length, body counter, checksum, payload store,
// read index and the output register.
// ----------------------------------------------------------------------------
module fbsp_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [fbsp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [fbsp_pkg::ByteW-1:0]           cfg_data_i,
  input  logic [fbsp_pkg::ByteW-1:0]           rx_byte_i,
  input  fbsp_pkg::ctrl_cmd_t                  cmd_i,
  output fbsp_pkg::dp_status_t                 status_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [fbsp_pkg::StatusW-1:0]         res_status_o,
  output logic [fbsp_pkg::ByteW-1:0]           command_o,
  output logic [fbsp_pkg::PlenW-1:0]           payload_length_o,
  output logic                                 payload_valid_o,
  output logic [fbsp_pkg::PlenW-1:0]           payload_position_o,
  output logic [fbsp_pkg::ByteW-1:0]           payload_byte_o,
  output logic                                 last_of_run_o
);

  logic [fbsp_pkg::ByteW-1:0]   first_hdr_q, second_hdr_q;
  logic [fbsp_pkg::LenW-1:0]    decl_len_q, body_cnt_q, body_cnt_d;
  logic [fbsp_pkg::ByteW-1:0]   sum_q, cmd_hold_q;
  logic [fbsp_pkg::AddrW-1:0]   rd_idx_q;
  logic [fbsp_pkg::PlenW-1:0]   plen, rd_pos;
  logic [fbsp_pkg::ByteW-1:0]   ram_rdata;
  logic                         ram_we;
  logic [fbsp_pkg::LenW-1:0]    wr_off;

  logic                         out_valid_q;
  logic [fbsp_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [fbsp_pkg::ByteW-1:0]   out_cmd_q, out_cmd_d;
  logic [fbsp_pkg::PlenW-1:0]   out_len_q, out_len_d, out_pos_q, out_pos_d;
  logic                         out_pvalid_q, out_pvalid_d;
  logic [fbsp_pkg::ByteW-1:0]   out_byte_q, out_byte_d;
  logic                         out_last_q, out_last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_hdr_q  <= fbsp_pkg::FirstHeaderReset;
      second_hdr_q <= fbsp_pkg::SecondHeaderReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == fbsp_pkg::CfgFirstHeader) begin
        first_hdr_q <= cfg_data_i;
      end else if (cfg_index_i == fbsp_pkg::CfgSecondHeader) begin
        second_hdr_q <= cfg_data_i;
      end
    end
  end

  assign body_cnt_d = body_cnt_q + fbsp_pkg::LenW'(1);
  assign plen       = fbsp_pkg::PlenW'(decl_len_q - fbsp_pkg::LenW'(1));
  assign rd_pos     = fbsp_pkg::PlenW'(rd_idx_q);
  assign wr_off     = body_cnt_d - fbsp_pkg::LenW'(2);

  assign status_o.is_first  = (rx_byte_i == first_hdr_q);
  assign status_o.is_second = (rx_byte_i == second_hdr_q);
  assign status_o.len_bad   = (rx_byte_i == '0) ||
                              (rx_byte_i > fbsp_pkg::ByteW'(fbsp_pkg::MaxPayload + 1));
  assign status_o.body_end  = (body_cnt_d > decl_len_q);
  assign status_o.sum_ok    = (rx_byte_i == sum_q);
  assign status_o.plen_zero = (plen == '0);
  assign status_o.rd_last   = (rd_pos == plen - fbsp_pkg::PlenW'(1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_len_q <= '0;
      body_cnt_q <= '0;
      sum_q      <= '0;
      cmd_hold_q <= '0;
    end else if (cmd_i.take_length) begin
      decl_len_q <= rx_byte_i[fbsp_pkg::LenW-1:0];
      body_cnt_q <= '0;
      sum_q      <= rx_byte_i;
    end else if (cmd_i.take_body) begin
      body_cnt_q <= body_cnt_d;
      if (!status_o.body_end) begin
        sum_q <= sum_q + rx_byte_i;
        if (body_cnt_d == fbsp_pkg::LenW'(1)) begin
          cmd_hold_q <= rx_byte_i;
        end
      end
    end
  end

  assign ram_we = cmd_i.take_body && !status_o.body_end &&
                  (body_cnt_d != fbsp_pkg::LenW'(1));

  fbsp_ram #(
    .Width (fbsp_pkg::ByteW),
    .Depth (fbsp_pkg::MaxPayload)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (wr_off[fbsp_pkg::AddrW-1:0]),
    .wr_data_i (rx_byte_i),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_start) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_q <= rd_idx_q + fbsp_pkg::AddrW'(1);
    end
  end

  always_comb begin
    out_status_d = fbsp_pkg::StGood;
    out_cmd_d    = '0;
    out_len_d    = '0;
    out_pvalid_d = 1'b0;
    out_pos_d    = '0;
    out_byte_d   = '0;
    out_last_d   = 1'b1;
    case (cmd_i.out_sel)
      fbsp_pkg::OutLenErr: begin
        out_status_d = fbsp_pkg::StLenErr;
      end
      fbsp_pkg::OutSumErr: begin
        out_status_d = fbsp_pkg::StSumErr;
      end
      fbsp_pkg::OutGoodEmpty: begin
        out_cmd_d = cmd_hold_q;
      end
      fbsp_pkg::OutPayload: begin
        out_cmd_d    = cmd_hold_q;
        out_len_d    = plen;
        out_pvalid_d = 1'b1;
        out_pos_d    = rd_pos;
        out_byte_d   = ram_rdata;
        out_last_d   = status_o.rd_last;
      end
      default: begin
        out_status_d = fbsp_pkg::StGood;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= out_status_d;
      out_cmd_q    <= out_cmd_d;
      out_len_q    <= out_len_d;
      out_pvalid_q <= out_pvalid_d;
      out_pos_q    <= out_pos_d;
      out_byte_q   <= out_byte_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign res_status_o       = out_status_q;
  assign command_o          = out_cmd_q;
  assign payload_length_o   = out_len_q;
  assign payload_valid_o    = out_pvalid_q;
  assign payload_position_o = out_pos_q;
  assign payload_byte_o     = out_byte_q;
  assign last_of_run_o      = out_last_q;

endmodule

### rtl/fbsp_ctrl.sv
// ----------------------------------------------------------------------------
// Parser controller
// Frame state machine: header hunt, length, body, and the payload read-out.
// ----------------------------------------------------------------------------
module fbsp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fbsp_pkg::dp_status_t status_i,
  output fbsp_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] SHunt   = 3'd0;
  localparam logic [2:0] SSecond = 3'd1;
  localparam logic [2:0] SLength = 3'd2;
  localparam logic [2:0] SBody   = 3'd3;
  localparam logic [2:0] SRead   = 3'd4;
  localparam logic [2:0] SWait   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      SHunt: begin
        in_ready_o = 1'b1;
        if (in_fire && status_i.is_first) begin
          state_d = SSecond;
        end
      end
      SSecond: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          state_d = status_i.is_second ? SLength : SHunt;
        end
      end
      SLength: begin
        in_ready_o = status_i.out_free;
        if (in_fire) begin
          if (status_i.len_bad) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = fbsp_pkg::OutLenErr;
            state_d        = SHunt;
          end else begin
            cmd_o.take_length = 1'b1;
            state_d           = SBody;
          end
        end
      end
      SBody: begin
        in_ready_o = status_i.out_free;
        if (in_fire) begin
          cmd_o.take_body = 1'b1;
          if (status_i.body_end) begin
            if (!status_i.sum_ok) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_sel  = fbsp_pkg::OutSumErr;
              state_d        = SHunt;
            end else if (status_i.plen_zero) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_sel  = fbsp_pkg::OutGoodEmpty;
              state_d        = SHunt;
            end else begin
              cmd_o.rd_start = 1'b1;
              state_d        = SRead;
            end
          end
        end
      end
      SRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = SWait;
      end
      SWait: begin
        cmd_o.out_sel = fbsp_pkg::OutPayload;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.rd_last) begin
            state_d = SHunt;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = SRead;
          end
        end
      end
      default: begin
        state_d = SHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SHunt;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/framed_byte_stream_parser.sv
// ----------------------------------------------------------------------------
// Framed byte stream parser
// Finds frames of two header bytes, a length, a command, a payload and an
// 8-bit checksum in a byte stream and reports each frame as results.
// ----------------------------------------------------------------------------
// The input channel takes one received byte per request. The output channel
// gives results: one per payload byte of a good frame, one for a good frame
// with no payload, and one for a length or checksum error.
// The configuration channel writes the two header byte values; index 0 is
// the first header byte and index 1 the second. Other indexes are ignored.
// A header byte is taken in the cycle it is offered. A length or body byte
// is taken only while the output register is free or being emptied.
// An error or an empty good frame appears at the output in the cycle after
// the byte that causes it. A payload run starts after the checksum byte;
// for each payload byte, state SRead does the registered read of the payload
// store, then state SWait loads the output register; no byte is taken in a run.
// Reset returns the parser to header hunting, empties the output register
// and loads the header values 170 and 85. When the receiver stalls, the
// held result stays and the parser waits; no result is lost.
// ----------------------------------------------------------------------------
module framed_byte_stream_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fbsp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fbsp_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [fbsp_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fbsp_pkg::StatusW-1:0] status_o,
  output logic [fbsp_pkg::ByteW-1:0]   command_o,
  output logic [fbsp_pkg::PlenW-1:0]   payload_length_o,
  output logic                         payload_valid_o,
  output logic [fbsp_pkg::PlenW-1:0]   payload_position_o,
  output logic [fbsp_pkg::ByteW-1:0]   payload_byte_o,
  output logic                         last_of_run_o
);

  fbsp_pkg::ctrl_cmd_t  cmd;
  fbsp_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  fbsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  fbsp_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .rx_byte_i          (rx_byte_i),
    .cmd_i              (cmd),
    .status_o           (dp_status),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .res_status_o       (status_o),
    .command_o          (command_o),
    .payload_length_o   (payload_length_o),
    .payload_valid_o    (payload_valid_o),
    .payload_position_o (payload_position_o),
    .payload_byte_o     (payload_byte_o),
    .last_of_run_o      (last_of_run_o)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> dp_status.out_free)
    else $error("Pending result overwritten.");

  a_no_input_during_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !in_ready_o)
    else $error("Input taken during payload read-out.");

  a_position_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (payload_position_o < payload_length_o))
    else $error("Payload position beyond payload length.");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_valid_o) |-> last_of_run_o)
    else $error("Single result not marked last.");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed byte stream parser testbench
// Streams received bytes into the parser through a bursty driver and checks
// every frame report against an in-bench frame decoder. A short directed
// sequence covers the header, length and checksum cases. Random frame
// traffic then runs under several header settings while the report side
// stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [fbsp_pkg::CfgIdxW-1:0] CfgUnusedLow  = 2'd2;
  localparam logic [fbsp_pkg::CfgIdxW-1:0] CfgUnusedHigh = 2'd3;

  typedef enum logic [1:0] {SeekFirst, SeekSecond, TakeLength, TakeBody} seek_phase_e;
  typedef enum logic [1:0] {RecvSteady, RecvLight, RecvHeavy} recv_mode_e;

  typedef struct packed {
    logic [fbsp_pkg::StatusW-1:0] status;
    logic [fbsp_pkg::ByteW-1:0]   command;
    logic [fbsp_pkg::PlenW-1:0]   plen;
    logic                         pvalid;
    logic [fbsp_pkg::PlenW-1:0]   pos;
    logic [fbsp_pkg::ByteW-1:0]   pbyte;
    logic                         last;
  } frame_report_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [fbsp_pkg::CfgIdxW-1:0] cfg_index_i = fbsp_pkg::CfgFirstHeader;
  logic [fbsp_pkg::ByteW-1:0]   cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic [fbsp_pkg::ByteW-1:0]   rx_byte_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [fbsp_pkg::StatusW-1:0] status_o;
  logic [fbsp_pkg::ByteW-1:0]   command_o;
  logic [fbsp_pkg::PlenW-1:0]   payload_length_o;
  logic                         payload_valid_o;
  logic [fbsp_pkg::PlenW-1:0]   payload_position_o;
  logic [fbsp_pkg::ByteW-1:0]   payload_byte_o;
  logic                         last_of_run_o;

  // Decoder state and header settings.
  seek_phase_e                seek_ph  = SeekFirst;
  logic [fbsp_pkg::ByteW-1:0] sync_a   = fbsp_pkg::FirstHeaderReset;
  logic [fbsp_pkg::ByteW-1:0] sync_b   = fbsp_pkg::SecondHeaderReset;
  int                         decl_len = 0;
  int                         body_cnt = 0;
  logic [fbsp_pkg::ByteW-1:0] csum     = '0;
  logic [fbsp_pkg::ByteW-1:0] cmd_hold = '0;
  logic [fbsp_pkg::ByteW-1:0] body_mem [fbsp_pkg::MaxPayload];

  logic [fbsp_pkg::ByteW-1:0] rx_stream_q [$];
  frame_report_t              frame_report_q [$];
  int                         mismatch_cnt = 0;
  int                         report_cnt   = 0;

  int         burst_left = 0;
  int         gap_left   = 0;
  int         hold_left  = 0;
  bit         hold_done  = 1'b0;
  int         mode_left  = 0;
  recv_mode_e recv_mode  = RecvSteady;

  framed_byte_stream_parser dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic void add_report(logic [fbsp_pkg::StatusW-1:0] st,
                                     logic [fbsp_pkg::ByteW-1:0] cmd,
                                     logic [fbsp_pkg::PlenW-1:0] plen, logic pv,
                                     logic [fbsp_pkg::PlenW-1:0] pos,
                                     logic [fbsp_pkg::ByteW-1:0] pb,
                                     logic last);
    frame_report_t r;
    r = '{status: st, command: cmd, plen: plen, pvalid: pv, pos: pos, pbyte: pb,
          last: last};
    frame_report_q.push_back(r);
  endfunction

  function automatic void restart_hunt();
    seek_ph  = SeekFirst;
    decl_len = 0;
    body_cnt = 0;
    csum     = '0;
  endfunction

  function automatic void parse_byte(logic [fbsp_pkg::ByteW-1:0] b);
    int n_pl;
    case (seek_ph)
      SeekFirst: begin
        if (b == sync_a) seek_ph = SeekSecond;
      end
      SeekSecond: begin
        seek_ph = (b == sync_b) ? TakeLength : SeekFirst;
      end
      TakeLength: begin
        if (b == 0 || b > fbsp_pkg::MaxPayload + 1) begin
          restart_hunt();
          add_report(fbsp_pkg::StLenErr, '0, '0, 1'b0, '0, '0, 1'b1);
        end else begin
          decl_len = int'(b);
          body_cnt = 0;
          csum     = b;
          seek_ph  = TakeBody;
        end
      end
      default: begin
        body_cnt++;
        if (body_cnt >= decl_len + 1) begin
          n_pl = decl_len - 1;
          if (b != csum) begin
            add_report(fbsp_pkg::StSumErr, '0, '0, 1'b0, '0, '0, 1'b1);
          end else if (n_pl == 0) begin
            add_report(fbsp_pkg::StGood, cmd_hold, '0, 1'b0, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < n_pl; i++) begin
              add_report(fbsp_pkg::StGood, cmd_hold, fbsp_pkg::PlenW'(n_pl), 1'b1,
                         fbsp_pkg::PlenW'(i), body_mem[i], i == n_pl - 1);
            end
          end
          restart_hunt();
        end else begin
          if (body_cnt == 1) cmd_hold = b;
          else body_mem[body_cnt-2] = b;
          csum = csum + b;
        end
      end
    endcase
  endfunction

  function automatic logic [fbsp_pkg::ByteW-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return fbsp_pkg::ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_header();
    rx_stream_q.push_back(sync_a);
    rx_stream_q.push_back(sync_b);
  endfunction

  function automatic void push_frame(int len, logic [fbsp_pkg::ByteW-1:0] cmd, bit bad_sum);
    logic [fbsp_pkg::ByteW-1:0] sum;
    logic [fbsp_pkg::ByteW-1:0] pb;
    push_header();
    rx_stream_q.push_back(fbsp_pkg::ByteW'(len));
    rx_stream_q.push_back(cmd);
    sum = fbsp_pkg::ByteW'(len) + cmd;
    for (int i = 1; i < len; i++) begin
      pb = rand_byte();
      rx_stream_q.push_back(pb);
      sum = sum + pb;
    end
    if (bad_sum) sum = sum ^ (8'h01 << $urandom_range(0, 7));
    rx_stream_q.push_back(sum);
  endfunction

  function automatic logic [fbsp_pkg::ByteW-1:0] byte_except(
      logic [fbsp_pkg::ByteW-1:0] avoid);
    logic [fbsp_pkg::ByteW-1:0] b;
    b = rand_byte();
    while (b == avoid) b = fbsp_pkg::ByteW'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic void add_traffic(int n_items);
    int start;
    int pick;
    int len;
    start = rx_stream_q.size();
    while (rx_stream_q.size() - start < n_items) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ?
             $urandom_range(fbsp_pkg::MaxPayload - 3, fbsp_pkg::MaxPayload + 1) :
             $urandom_range(1, 8);
      if (pick < 65) begin
        push_frame(len, rand_byte(), 1'b0);
      end else if (pick < 75) begin
        push_frame(len, rand_byte(), 1'b1);
      end else if (pick < 83) begin
        push_header();
        rx_stream_q.push_back(($urandom_range(0, 2) == 0) ?
                              '0 :
                              fbsp_pkg::ByteW'($urandom_range(fbsp_pkg::MaxPayload + 2,
                                                              255)));
      end else if (pick < 91) begin
        rx_stream_q.push_back(sync_a);
        if (sync_a != sync_b && $urandom_range(0, 1) == 0) rx_stream_q.push_back(sync_a);
        else rx_stream_q.push_back(byte_except(sync_b));
      end else begin
        repeat ($urandom_range(1, 4)) rx_stream_q.push_back(byte_except(sync_a));
      end
    end
  endfunction

  task automatic write_reg(logic [fbsp_pkg::CfgIdxW-1:0] idx,
                           logic [fbsp_pkg::ByteW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == fbsp_pkg::CfgFirstHeader) sync_a = val;
    else if (idx == fbsp_pkg::CfgSecondHeader) sync_b = val;
  endtask

  task automatic wait_idle();
    while (rx_stream_q.size() != 0 || in_valid_i || frame_report_q.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : byte_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) parse_byte(rx_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (rx_stream_q.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_stream_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : report_monitor
    frame_report_t want_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (frame_report_q.size() == 0) begin
          $display("%0t ns: unexpected report, expected none, actual status %0d command %0d",
                   $time, status_o, command_o);
          mismatch_cnt++;
        end else begin
          want_r = frame_report_q.pop_front();
          cmp_field("status", fbsp_pkg::ByteW'(want_r.status),
                    fbsp_pkg::ByteW'(status_o));
          cmp_field("command", want_r.command, command_o);
          cmp_field("payload_length", fbsp_pkg::ByteW'(want_r.plen),
                    fbsp_pkg::ByteW'(payload_length_o));
          cmp_field("payload_valid", fbsp_pkg::ByteW'(want_r.pvalid),
                    fbsp_pkg::ByteW'(payload_valid_o));
          cmp_field("payload_position", fbsp_pkg::ByteW'(want_r.pos),
                    fbsp_pkg::ByteW'(payload_position_o));
          cmp_field("payload_byte", want_r.pbyte, payload_byte_o);
          cmp_field("last_of_run", fbsp_pkg::ByteW'(want_r.last),
                    fbsp_pkg::ByteW'(last_of_run_o));
        end
        report_cnt++;
      end
      if (mode_left > 0) begin
        mode_left--;
      end else begin
        recv_mode = recv_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(8, 48);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && report_cnt >= 10 && rx_stream_q.size() > 20) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_ready_i <= 1'b0;
      end else begin
        case (recv_mode)
          RecvSteady: out_ready_i <= 1'b1;
          RecvLight:  out_ready_i <= ($urandom_range(0, 3) != 0);
          default:    out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : run_limit
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [fbsp_pkg::ByteW-1:0] v;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default headers: empty frame, bad lengths, wrong second header that
    // repeats the first header value, a one-byte payload and a bad checksum.
    push_frame(1, 8'hFF, 1'b0);
    push_header();
    rx_stream_q.push_back(8'h00);
    push_header();
    rx_stream_q.push_back(fbsp_pkg::ByteW'(fbsp_pkg::MaxPayload + 2));
    rx_stream_q.push_back(sync_a);
    rx_stream_q.push_back(sync_a);
    rx_stream_q.push_back(sync_b);
    push_frame(2, 8'h00, 1'b0);
    push_frame(3, rand_byte(), 1'b1);
    wait_idle();

    write_reg(fbsp_pkg::CfgFirstHeader, 8'h00);
    write_reg(fbsp_pkg::CfgSecondHeader, 8'hFF);
    write_reg(CfgUnusedLow, rand_byte());
    write_reg(CfgUnusedHigh, rand_byte());
    push_frame(fbsp_pkg::MaxPayload + 1, rand_byte(), 1'b0);
    add_traffic(100);
    wait_idle();

    write_reg(fbsp_pkg::CfgFirstHeader, 8'hFF);
    write_reg(fbsp_pkg::CfgSecondHeader, 8'h00);
    push_header();
    rx_stream_q.push_back(8'hFF);
    add_traffic(80);
    wait_idle();

    v = rand_byte();
    write_reg(fbsp_pkg::CfgFirstHeader, v);
    write_reg(fbsp_pkg::CfgSecondHeader, v);
    add_traffic(60);
    wait_idle();

    v = rand_byte();
    write_reg(fbsp_pkg::CfgFirstHeader, v);
    write_reg(fbsp_pkg::CfgSecondHeader, byte_except(v));
    add_traffic(60);
    wait_idle();

    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
